// File: rtl/oled_page_framebuffer_refresh_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page framebuffer refresh block
// Concurrent checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef OLED_PAGE_FRAMEBUFFER_REFRESH_ASSERT_SVH
`define OLED_PAGE_FRAMEBUFFER_REFRESH_ASSERT_SVH
`ifndef SYNTHESIS
`define OFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ofr: same-cycle check failed");
`define OFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ofr: next-cycle check failed");
`else
`define OFR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define OFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ofr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofr_pkg
// Types, constants and decode helpers of the page framebuffer refresh block.
// ----------------------------------------------------------------------------
package ofr_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;

  localparam logic [7:0] DEV_ADDR_RST  = 8'd120;

  // control bytes after the address
  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  // panel opcodes
  localparam logic [7:0] OP_COL_LOW    = 8'h00;
  localparam logic [7:0] OP_COL_HIGH   = 8'h10;
  localparam logic [7:0] OP_START_LINE = 8'h40;
  localparam logic [7:0] OP_PAGE_BASE  = 8'hB0;
  localparam logic [7:0] OP_COL_OFS    = 8'h02;

  typedef enum logic [2:0] {
    ACT_SET_PIXEL   = 3'd0,
    ACT_CLEAR_PIXEL = 3'd1,
    ACT_WRITE_BYTE  = 3'd2,
    ACT_READ_PIXEL  = 3'd3,
    ACT_FILL        = 3'd4,
    ACT_START       = 3'd5,
    ACT_TICK        = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_OPEN  = 2'd1,
    PH_PAGES = 2'd2,
    PH_CLOSE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2,
    ST_FILL  = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep_we;
    logic sweep_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic is_fill;
    logic sweep_last;
  } dp_status_t;

  typedef struct packed {
    logic [1:0] k;
    logic [1:0] sub;
  } hdr_pos_t;

  // command slot and byte within a run of three 3-byte transactions
  function automatic hdr_pos_t hdr_split(input logic [3:0] bp);
    hdr_pos_t r;
    case (bp)
      4'd0: r = '{k: 2'd0, sub: 2'd0};
      4'd1: r = '{k: 2'd0, sub: 2'd1};
      4'd2: r = '{k: 2'd0, sub: 2'd2};
      4'd3: r = '{k: 2'd1, sub: 2'd0};
      4'd4: r = '{k: 2'd1, sub: 2'd1};
      4'd5: r = '{k: 2'd1, sub: 2'd2};
      4'd6: r = '{k: 2'd2, sub: 2'd0};
      4'd7: r = '{k: 2'd2, sub: 2'd1};
      default: r = '{k: 2'd2, sub: 2'd2};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] open_cmd(input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0: r = OP_COL_LOW;
      2'd1: r = OP_COL_HIGH;
      default: r = OP_START_LINE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] page_cmd(input logic [1:0] k, input logic [3:0] page);
    logic [7:0] r;
    case (k)
      2'd0: r = OP_PAGE_BASE + {4'd0, page};
      2'd1: r = OP_COL_OFS;
      default: r = OP_COL_HIGH;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cmd_byte(input logic [1:0] sub, input logic [7:0] dev,
                                          input logic [7:0] op);
    logic [7:0] r;
    case (sub)
      2'd0: r = dev;
      2'd1: r = CTRL_CMD;
      default: r = op;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ofr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ofr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ofr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofr_ctrl
// Sequencer: post-reset clear sweep, item execute, fill sweep.
// ----------------------------------------------------------------------------
module ofr_ctrl import ofr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.sweep_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_EXEC;
      ST_EXEC:  state_next = status.is_fill ? ST_FILL : ST_IDLE;
      ST_FILL:  if (status.sweep_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.sweep_we   = 1'b1;
        cmd.sweep_zero = 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_FILL: begin
        cmd.sweep_we = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/ofr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofr_datapath
// Frame store, pixel edits, refresh stream generator and result registers.
// ----------------------------------------------------------------------------
module ofr_datapath import ofr_pkg::*; #(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic [2:0] action,
  input  logic [6:0] column,
  input  logic [5:0] row,
  input  logic [7:0] value,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  output logic [7:0] bus_byte,
  output logic       byte_valid,
  output logic       frame_start,
  output logic       frame_end,
  output logic       pixel_bit,
  output logic       refresh_busy,
  output logic       done
);

  localparam int PAGE_COUNT = DISPLAY_HEIGHT >> 3;
  localparam int CHUNK_LEN  = DISPLAY_WIDTH >> 3;
  localparam int STORE_SIZE = PAGE_COUNT * DISPLAY_WIDTH;
  localparam int AW         = $clog2(STORE_SIZE);

  logic [2:0]    item_action;
  logic [6:0]    item_column;
  logic [5:0]    item_row;
  logic [7:0]    item_value;
  logic [7:0]    dev_addr;

  phase_t        phase, phase_next;
  logic [3:0]    page_cnt, page_cnt_next;
  logic [2:0]    chunk_cnt, chunk_cnt_next;
  logic [4:0]    byte_pos, byte_pos_next;
  logic          in_header, in_header_next;
  logic [AW-1:0] sweep_cnt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [AW-1:0] pix_addr_in, stream_addr, item_pix_addr, item_byte_addr;
  logic          item_pix_ok, item_byte_ok, is_tick, is_read;
  logic [7:0]    mask;
  logic [3:0]    page_inc;
  hdr_pos_t      hp;
  logic [7:0]    e_byte;
  logic          e_st, e_en;

  ofr_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pix_addr_in = AW'(int'(row[5:3]) * DISPLAY_WIDTH + int'(column));
  assign stream_addr = AW'(int'(page_cnt) * DISPLAY_WIDTH + int'(chunk_cnt) * CHUNK_LEN
                           + int'(byte_pos) - 2);
  assign ram_raddr   = (action_t'(action) == ACT_TICK) ? stream_addr : pix_addr_in;

  assign item_pix_addr  = AW'(int'(item_row[5:3]) * DISPLAY_WIDTH + int'(item_column));
  assign item_byte_addr = AW'(int'(item_row) * DISPLAY_WIDTH + int'(item_column));
  assign item_pix_ok    = (int'(item_column) < DISPLAY_WIDTH) &&
                          (int'(item_row) < DISPLAY_HEIGHT) &&
                          (int'(item_row[5:3]) < PAGE_COUNT);
  assign item_byte_ok   = (int'(item_column) < DISPLAY_WIDTH) &&
                          (int'(item_row) < PAGE_COUNT);
  assign mask           = 8'd1 << item_row[2:0];
  assign is_tick        = cmd.exec && (action_t'(item_action) == ACT_TICK);
  assign is_read        = cmd.exec && (action_t'(item_action) == ACT_READ_PIXEL);

  assign status.is_fill    = (action_t'(item_action) == ACT_FILL);
  assign status.sweep_last = (sweep_cnt == AW'(STORE_SIZE - 1));

  // store writes: sweeps, pixel read-modify-write, page byte
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_cnt;
    ram_wdata = 8'd0;
    if (cmd.sweep_we) begin
      ram_we    = 1'b1;
      ram_wdata = cmd.sweep_zero ? 8'd0 : item_value;
    end else if (cmd.exec) begin
      case (action_t'(item_action))
        ACT_SET_PIXEL: begin
          ram_we    = item_pix_ok;
          ram_waddr = item_pix_addr;
          ram_wdata = ram_rdata | mask;
        end
        ACT_CLEAR_PIXEL: begin
          ram_we    = item_pix_ok;
          ram_waddr = item_pix_addr;
          ram_wdata = ram_rdata & ~mask;
        end
        ACT_WRITE_BYTE: begin
          ram_we    = item_byte_ok;
          ram_waddr = item_byte_addr;
          ram_wdata = item_value;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  // refresh stream step
  always_comb begin
    phase_next     = phase;
    page_cnt_next  = page_cnt;
    chunk_cnt_next = chunk_cnt;
    byte_pos_next  = byte_pos;
    in_header_next = in_header;
    e_byte         = 8'd0;
    e_st           = 1'b0;
    e_en           = 1'b0;
    hp             = hdr_split(byte_pos[3:0]);
    page_inc       = page_cnt + 4'd1;
    if (cmd.exec && (action_t'(item_action) == ACT_START) && (phase == PH_IDLE)) begin
      phase_next     = PH_OPEN;
      page_cnt_next  = 4'd0;
      chunk_cnt_next = 3'd0;
      byte_pos_next  = 5'd0;
      in_header_next = 1'b0;
    end else if (is_tick) begin
      case (phase)
        PH_OPEN: begin
          e_byte        = cmd_byte(hp.sub, dev_addr, open_cmd(hp.k));
          e_st          = (hp.sub == 2'd0);
          e_en          = (hp.sub == 2'd2);
          byte_pos_next = byte_pos + 5'd1;
          if (byte_pos == 5'd8) begin
            phase_next     = PH_PAGES;
            page_cnt_next  = 4'd0;
            chunk_cnt_next = 3'd0;
            byte_pos_next  = 5'd0;
            in_header_next = 1'b1;
          end
        end
        PH_PAGES: begin
          if (in_header) begin
            e_byte        = cmd_byte(hp.sub, dev_addr, page_cmd(hp.k, page_cnt));
            e_st          = (hp.sub == 2'd0);
            e_en          = (hp.sub == 2'd2);
            byte_pos_next = byte_pos + 5'd1;
            if (byte_pos == 5'd8) begin
              in_header_next = 1'b0;
              byte_pos_next  = 5'd0;
              chunk_cnt_next = 3'd0;
            end
          end else begin
            if (byte_pos == 5'd0) begin
              e_byte = dev_addr;
              e_st   = 1'b1;
            end else if (byte_pos == 5'd1) begin
              e_byte = CTRL_DATA;
            end else begin
              e_byte = ram_rdata;
            end
            if (byte_pos == 5'(CHUNK_LEN + 1)) begin
              e_en          = 1'b1;
              byte_pos_next = 5'd0;
              if (chunk_cnt == 3'd7) begin
                chunk_cnt_next = 3'd0;
                page_cnt_next  = page_inc;
                if (int'(page_inc) >= PAGE_COUNT) begin
                  phase_next    = PH_CLOSE;
                  page_cnt_next = 4'd0;
                end else begin
                  in_header_next = 1'b1;
                end
              end else begin
                chunk_cnt_next = chunk_cnt + 3'd1;
              end
            end else begin
              byte_pos_next = byte_pos + 5'd1;
            end
          end
        end
        PH_CLOSE: begin
          e_byte        = cmd_byte(hp.sub, dev_addr, page_cmd(hp.k, 4'd0));
          e_st          = (hp.sub == 2'd0);
          e_en          = (hp.sub == 2'd2);
          byte_pos_next = byte_pos + 5'd1;
          if (byte_pos == 5'd8) begin
            phase_next    = PH_IDLE;
            byte_pos_next = 5'd0;
          end
        end
        default: e_byte = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr  <= DEV_ADDR_RST;
      phase     <= PH_IDLE;
      page_cnt  <= 4'd0;
      chunk_cnt <= 3'd0;
      byte_pos  <= 5'd0;
      in_header <= 1'b0;
      sweep_cnt <= '0;
      done      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dev_addr <= cfg_data;
      end
      phase     <= phase_next;
      page_cnt  <= page_cnt_next;
      chunk_cnt <= chunk_cnt_next;
      byte_pos  <= byte_pos_next;
      in_header <= in_header_next;
      if (cmd.sweep_we) begin
        sweep_cnt <= status.sweep_last ? '0 : sweep_cnt + AW'(1);
      end
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action <= action;
      item_column <= column;
      item_row    <= row;
      item_value  <= value;
    end
    if (cmd.exec) begin
      bus_byte     <= e_byte;
      byte_valid   <= is_tick && (phase != PH_IDLE);
      frame_start  <= e_st;
      frame_end    <= e_en;
      pixel_bit    <= is_read && item_pix_ok && (|(ram_rdata & mask));
      refresh_busy <= (phase_next != PH_IDLE);
    end
  end

endmodule

// File: rtl/oled_page_framebuffer_refresh.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_page_framebuffer_refresh
// Page-organized monochrome frame store with a serial-bus refresh streamer.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         action, column, row, value
//  result    done (one cycle)     bus_byte, byte_valid, frame_start,
//                                 frame_end, pixel_bit, refresh_busy
//  config    cfg_valid/cfg_ready  cfg_data (bus address)
//
//  Every item is accepted (with its store read) and then executed; done
//  pulses in the cycle after execute, when the next item may be accepted
//  unless it was a fill, which then sweeps all PAGES*WIDTH store bytes,
//  one byte per cycle. After reset a clearing sweep of all PAGES*WIDTH
//  bytes (1024 by default) holds busy high. The result side has no stall.
// ----------------------------------------------------------------------------
`include "oled_page_framebuffer_refresh_assert.svh"
module oled_page_framebuffer_refresh import ofr_pkg::*; #(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] action,
  input  logic [6:0] column,
  input  logic [5:0] row,
  input  logic [7:0] value,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       done,
  output logic [7:0] bus_byte,
  output logic       byte_valid,
  output logic       frame_start,
  output logic       frame_end,
  output logic       pixel_bit,
  output logic       refresh_busy
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  ofr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ofr_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .action       (action),
    .column       (column),
    .row          (row),
    .value        (value),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .bus_byte     (bus_byte),
    .byte_valid   (byte_valid),
    .frame_start  (frame_start),
    .frame_end    (frame_end),
    .pixel_bit    (pixel_bit),
    .refresh_busy (refresh_busy),
    .done         (done)
  );

  `OFR_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `OFR_ASSERT_IMPLY(a_done_after_exec, clk, rst, done, $past(busy))
  `OFR_ASSERT_IMPLY(a_start_mid_stream, clk, rst, done && frame_start, byte_valid && refresh_busy)
  `OFR_ASSERT_IMPLY(a_tick_no_pixel, clk, rst, done && byte_valid, !pixel_bit)

endmodule

// File: tb/tb_oled_page_framebuffer_refresh.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oled_page_framebuffer_refresh
// Drives pixel, byte, fill, refresh and tick items into the frame store and
// checks every result against a cycle-free model of the store and the bus
// stream. The bus address is changed between phases, including 0x00 and 0xFF.
// ----------------------------------------------------------------------------
module tb_oled_page_framebuffer_refresh;
  import ofr_pkg::*;

  localparam int          PANEL_W     = DISPLAY_WIDTH_DEF;
  localparam int          PANEL_H     = DISPLAY_HEIGHT_DEF;
  localparam int          PAGES       = PANEL_H / 8;
  localparam int          CHUNK       = PANEL_W / 8;
  localparam int          STORE_BYTES = PAGES * PANEL_W;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [2:0]  ACT_RESERVED = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       sof;
    logic       eof;
    logic       pix;
    logic       running;
  } panel_out_t;

  class refresh_scoreboard;
    logic [7:0] pixel_store [0:STORE_BYTES-1];
    logic [7:0] dev_addr;
    phase_t     phase;
    logic [3:0] page_ctr;
    logic [2:0] chunk_ctr;
    logic [4:0] byte_pos;
    logic       in_hdr;
    int         streams_closed;
    int         errors;
    panel_out_t awaited [$];

    function new();
      for (int i = 0; i < STORE_BYTES; i++) pixel_store[i] = 8'h00;
      dev_addr = DEV_ADDR_RST;
      phase = PH_IDLE;
      page_ctr = 4'd0;
      chunk_ctr = 3'd0;
      byte_pos = 5'd0;
      in_hdr = 1'b0;
      streams_closed = 0;
      errors = 0;
    endfunction

    function void set_address(input logic [7:0] a);
      dev_addr = a;
    endfunction

    function bit idle();
      return phase == PH_IDLE;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // one byte of a three-byte command transaction
    function logic [7:0] txn_byte(input int sub, input logic [7:0] op,
                                  output logic st, output logic en);
      st = (sub == 0);
      en = (sub == 2);
      if (sub == 0) return dev_addr;
      if (sub == 1) return CTRL_CMD;
      return op;
    endfunction

    function logic [7:0] page_op(input int k, input logic [3:0] pg);
      if (k == 0) return OP_PAGE_BASE + {4'd0, pg};
      if (k == 1) return OP_COL_OFS;
      return OP_COL_HIGH;
    endfunction

    function logic [7:0] next_stream_byte(output logic st, output logic en);
      logic [7:0] b;
      logic [7:0] op;
      int bp;
      int idx;
      b = 8'h00;
      st = 1'b0;
      en = 1'b0;
      bp = int'(byte_pos);
      case (phase)
        PH_OPEN: begin
          op = (bp / 3 == 0) ? OP_COL_LOW : (bp / 3 == 1) ? OP_COL_HIGH : OP_START_LINE;
          b = txn_byte(bp % 3, op, st, en);
          byte_pos = 5'(bp + 1);
          if (bp + 1 >= 9) begin
            phase = PH_PAGES;
            page_ctr = 4'd0;
            chunk_ctr = 3'd0;
            byte_pos = 5'd0;
            in_hdr = 1'b1;
          end
        end
        PH_PAGES: begin
          if (in_hdr) begin
            b = txn_byte(bp % 3, page_op(bp / 3, page_ctr), st, en);
            byte_pos = 5'(bp + 1);
            if (bp + 1 >= 9) begin
              in_hdr = 1'b0;
              byte_pos = 5'd0;
              chunk_ctr = 3'd0;
            end
          end else begin
            if (bp == 0) begin
              b = dev_addr;
              st = 1'b1;
            end else if (bp == 1) begin
              b = CTRL_DATA;
            end else begin
              idx = page_ctr * PANEL_W + chunk_ctr * CHUNK + (bp - 2);
              b = (idx < STORE_BYTES) ? pixel_store[idx] : 8'h00;
            end
            if (bp + 1 >= CHUNK + 2) begin
              en = 1'b1;
              byte_pos = 5'd0;
              if (chunk_ctr >= 3'd7) begin
                chunk_ctr = 3'd0;
                page_ctr = page_ctr + 4'd1;
                if (page_ctr >= PAGES) begin
                  phase = PH_CLOSE;
                  page_ctr = 4'd0;
                end else begin
                  in_hdr = 1'b1;
                end
              end else begin
                chunk_ctr = chunk_ctr + 3'd1;
              end
            end else begin
              byte_pos = 5'(bp + 1);
            end
          end
        end
        PH_CLOSE: begin
          b = txn_byte(bp % 3, page_op(bp / 3, 4'd0), st, en);
          byte_pos = 5'(bp + 1);
          if (bp + 1 >= 9) begin
            phase = PH_IDLE;
            byte_pos = 5'd0;
            streams_closed++;
          end
        end
        default: ;
      endcase
      return b;
    endfunction

    function void note_command(input logic [2:0] act, input logic [6:0] col,
                               input logic [5:0] rw, input logic [7:0] v);
      panel_out_t o;
      logic       pix_ok;
      int         pidx;
      logic [7:0] mask;
      logic       st;
      logic       en;
      o = '0;
      pix_ok = (col < PANEL_W) && (rw < PANEL_H) && ((rw >> 3) < PAGES);
      pidx = (rw >> 3) * PANEL_W + col;
      mask = 8'(1 << rw[2:0]);
      case (act)
        ACT_SET_PIXEL:   if (pix_ok) pixel_store[pidx] = pixel_store[pidx] | mask;
        ACT_CLEAR_PIXEL: if (pix_ok) pixel_store[pidx] = pixel_store[pidx] & ~mask;
        ACT_WRITE_BYTE:  if (col < PANEL_W && rw < PAGES) pixel_store[rw * PANEL_W + col] = v;
        ACT_READ_PIXEL:  if (pix_ok) o.pix = |(pixel_store[pidx] & mask);
        ACT_FILL:        for (int i = 0; i < STORE_BYTES; i++) pixel_store[i] = v;
        ACT_START: begin
          if (phase == PH_IDLE) begin
            phase = PH_OPEN;
            page_ctr = 4'd0;
            chunk_ctr = 3'd0;
            byte_pos = 5'd0;
            in_hdr = 1'b0;
          end
        end
        ACT_TICK: begin
          if (phase != PH_IDLE) begin
            o.data = next_stream_byte(st, en);
            o.sof = st;
            o.eof = en;
            o.vld = 1'b1;
          end
        end
        default: ;
      endcase
      o.running = (phase != PH_IDLE);
      awaited.push_back(o);
    endfunction

    function void check_result(input panel_out_t got);
      panel_out_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with nothing expected", $realtime);
        return;
      end
      want = awaited.pop_front();
      if (got.data !== want.data || got.vld !== want.vld || got.sof !== want.sof ||
          got.eof !== want.eof || got.pix !== want.pix || got.running !== want.running) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp byte %h vld %b sof %b eof %b pix %b busy %b, got byte %h vld %b sof %b eof %b pix %b busy %b",
                   $realtime, want.data, want.vld, want.sof, want.eof, want.pix, want.running,
                   got.data, got.vld, got.sof, got.eof, got.pix, got.running);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] cmd_action;
  logic [6:0] cmd_column;
  logic [5:0] cmd_row;
  logic [7:0] cmd_value;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       done;
  logic [7:0] bus_byte;
  logic       byte_valid;
  logic       frame_start;
  logic       frame_end;
  logic       pixel_bit;
  logic       refresh_busy;

  refresh_scoreboard sb;
  bit                burst;
  int                cycles;

  oled_page_framebuffer_refresh dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (cmd_action),
    .column       (cmd_column),
    .row          (cmd_row),
    .value        (cmd_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .bus_byte     (bus_byte),
    .byte_valid   (byte_valid),
    .frame_start  (frame_start),
    .frame_end    (frame_end),
    .pixel_bit    (pixel_bit),
    .refresh_busy (refresh_busy)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(panel_out_t'{data: bus_byte, vld: byte_valid, sof: frame_start,
                                   eof: frame_end, pix: pixel_bit, running: refresh_busy});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_oled_page_framebuffer_refresh failed");
      $finish;
    end
  end

  task automatic issue(input logic [2:0] a, input logic [6:0] c, input logic [5:0] rw,
                       input logic [7:0] v);
    int gap;
    if ($urandom_range(0, 19) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    cmd_action <= a;
    cmd_column <= c;
    cmd_row    <= rw;
    cmd_value  <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(a, c, rw, v);
  endtask

  // fill keeps busy high after its result, so wait on busy as well
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_address(a);
  endtask

  task automatic random_item(input int tick_pct);
    int         r;
    logic [2:0] a;
    logic [6:0] c;
    logic [5:0] rw;
    logic [7:0] v;
    c  = 7'($urandom_range(0, 127));
    rw = 6'($urandom_range(0, 63));
    v  = 8'($urandom_range(0, 255));
    r  = $urandom_range(0, 99);
    if (r < tick_pct) begin
      a = ACT_TICK;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 6) a = ACT_START;
      else if (r < 26) a = ACT_SET_PIXEL;
      else if (r < 40) a = ACT_CLEAR_PIXEL;
      else if (r < 58) begin
        a = ACT_WRITE_BYTE;
        if ($urandom_range(0, 7) != 0) rw = 6'($urandom_range(0, PAGES - 1));
      end
      else if (r < 84) a = ACT_READ_PIXEL;
      else if (r < 86) a = ACT_FILL;
      else if (r < 90) a = ACT_RESERVED;
      else a = ACT_TICK;
    end
    if (sb.idle() && $urandom_range(0, 3) != 0) a = ACT_START;
    issue(a, c, rw, v);
  endtask

  initial begin
    int n;
    clk        = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    cmd_action = ACT_TICK;
    cmd_column = 7'd0;
    cmd_row    = 6'd0;
    cmd_value  = 8'h00;
    cfg_valid  = 1'b0;
    cfg_data   = 8'h00;
    cycles     = 0;
    burst      = 1'b0;
    sb         = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, out-of-range page writes, idle tick, start while busy,
    // store edits while the stream runs
    issue(ACT_TICK,        7'd5,   6'd9,  8'h33);
    issue(ACT_SET_PIXEL,   7'd0,   6'd0,  8'h00);
    issue(ACT_SET_PIXEL,   7'd127, 6'd63, 8'hFF);
    issue(ACT_READ_PIXEL,  7'd0,   6'd0,  8'h00);
    issue(ACT_READ_PIXEL,  7'd127, 6'd63, 8'h00);
    issue(ACT_READ_PIXEL,  7'd1,   6'd0,  8'h00);
    issue(ACT_CLEAR_PIXEL, 7'd127, 6'd63, 8'h00);
    issue(ACT_READ_PIXEL,  7'd127, 6'd63, 8'h00);
    issue(ACT_WRITE_BYTE,  7'd127, 6'd7,  8'hFF);
    issue(ACT_READ_PIXEL,  7'd127, 6'd56, 8'h00);
    issue(ACT_WRITE_BYTE,  7'd3,   6'd8,  8'hA5);
    issue(ACT_WRITE_BYTE,  7'd3,   6'd63, 8'h5A);
    issue(ACT_READ_PIXEL,  7'd3,   6'd0,  8'h00);
    issue(ACT_FILL,        7'd0,   6'd0,  8'hFF);
    issue(ACT_READ_PIXEL,  7'd64,  6'd31, 8'h00);
    issue(ACT_FILL,        7'd0,   6'd0,  8'h00);
    issue(ACT_RESERVED,    7'd127, 6'd63, 8'hFF);
    issue(ACT_START,       7'd0,   6'd0,  8'h00);
    issue(ACT_TICK,        7'd0,   6'd0,  8'h00);
    issue(ACT_START,       7'd0,   6'd0,  8'h00);
    issue(ACT_TICK,        7'd0,   6'd0,  8'h00);
    issue(ACT_WRITE_BYTE,  7'd2,   6'd0,  8'hC3);
    issue(ACT_SET_PIXEL,   7'd4,   6'd7,  8'h00);
    for (int i = 0; i < 6; i++) issue(ACT_TICK, 7'd0, 6'd0, 8'h00);

    // phase 1: address 0x00, mostly ticks, at least 300 items and until a whole stream has closed
    write_address(8'h00);
    n = 0;
    while (n < 300 || sb.streams_closed == 0) begin
      random_item(90);
      n++;
    end

    write_address(8'hFF);
    for (int i = 0; i < 60; i++) random_item(50);

    write_address(8'($urandom_range(1, 254)));
    for (int i = 0; i < 60; i++) random_item(50);

    wait_quiet();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_oled_page_framebuffer_refresh passed");
    else
      $display("tb_oled_page_framebuffer_refresh failed");
    $finish;
  end

endmodule
